>>> hdl/i2cms_pkg.sv
// Types, codes and helpers shared by the I2C master transaction sequencer.
`default_nettype none
package i2cms_pkg;

  // Sequencer phases.
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_WRITE_ONE  = 4'd1;
  localparam logic [3:0] PH_WRITE_NEXT = 4'd2;
  localparam logic [3:0] PH_WRITE_FINAL = 4'd3;
  localparam logic [3:0] PH_READ_ONE   = 4'd4;
  localparam logic [3:0] PH_READ_FIRST = 4'd5;
  localparam logic [3:0] PH_READ_NEXT  = 4'd6;
  localparam logic [3:0] PH_READ_FINAL = 4'd7;
  localparam logic [3:0] PH_READ_WAIT  = 4'd8;

  // Controller commands.
  localparam logic [3:0] CMD_NONE        = 4'd0;
  localparam logic [3:0] CMD_SINGLE_SEND = 4'd1;
  localparam logic [3:0] CMD_SEND_START  = 4'd2;
  localparam logic [3:0] CMD_SEND_CONT   = 4'd3;
  localparam logic [3:0] CMD_SEND_FINISH = 4'd4;
  localparam logic [3:0] CMD_SINGLE_RECV = 4'd5;
  localparam logic [3:0] CMD_RECV_START  = 4'd6;
  localparam logic [3:0] CMD_RECV_CONT   = 4'd7;
  localparam logic [3:0] CMD_RECV_FINISH = 4'd8;

  // Input command codes.
  localparam logic CMD_IN_START = 1'b0;
  localparam logic CMD_IN_DONE  = 1'b1;

  // Transaction kinds.
  localparam logic [2:0] KIND_BYTE_WRITE = 3'd0;
  localparam logic [2:0] KIND_SUB_WRITE  = 3'd1;
  localparam logic [2:0] KIND_RAW_WRITE  = 3'd2;
  localparam logic [2:0] KIND_BYTE_READ  = 3'd3;
  localparam logic [2:0] KIND_SUB_READ   = 3'd4;
  localparam logic [2:0] KIND_RAW_READ   = 3'd5;

  // Subaddress form codes.
  localparam logic [1:0] SUB_EIGHT_PLUS_X = 2'd0;

  localparam logic [2:0] EIGHT_PLUS_X_MASK = 3'h7;

  typedef struct packed {
    logic        command;
    logic [2:0]  kind;
    logic [7:0]  device_address;
    logic [23:0] sub_address;
    logic [1:0]  sub_size;
    logic [7:0]  byte_count;
    logic [7:0]  write_byte;
    logic [7:0]  read_byte;
  } in_t;

  typedef struct packed {
    logic [3:0] master_command;
    logic       address_valid;
    logic [6:0] slave_address;
    logic       read_direction;
    logic       put_valid;
    logic [7:0] put_byte;
    logic       store_valid;
    logic [7:0] store_byte;
    logic [7:0] next_index;
    logic       busy_res;
    logic       rejected;
  } out_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [6:0]  held_slave_address;
    logic [23:0] held_sub_address;
    logic [1:0]  sub_bytes_left;
    logic [7:0]  bytes_left;
    logic        read_after_address;
    logic [7:0]  buffer_position;
  } state_t;

  // Subaddress byte k, counting from the least significant byte.
  function automatic logic [7:0] sub_byte(logic [23:0] sub, logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = sub[7:0];
      2'd1:    b = sub[15:8];
      2'd2:    b = sub[23:16];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> hdl/i2cms_step.sv
// Next-state and result logic for one sequencer event.
`default_nettype none
module i2cms_step (
  input  i2cms_pkg::state_t state_i,
  input  i2cms_pkg::in_t    item_i,
  output i2cms_pkg::state_t state_o,
  output i2cms_pkg::out_t   result_o
);
  import i2cms_pkg::*;

  logic [6:0] sla;
  logic [6:0] sla_sub;
  logic [1:0] nsub;
  logic [7:0] count_sub;
  logic [1:0] sub_left_dec;
  logic [7:0] bytes_dec;
  logic [7:0] pos_inc;

  assign sla          = item_i.device_address[7:1];
  assign sla_sub      = (item_i.sub_size == SUB_EIGHT_PLUS_X)
                        ? (sla | {4'd0, item_i.sub_address[10:8] & EIGHT_PLUS_X_MASK})
                        : sla;
  assign nsub         = (item_i.sub_size == SUB_EIGHT_PLUS_X) ? 2'd1 : item_i.sub_size;
  assign count_sub    = (item_i.byte_count == 8'd0) ? 8'd1 : item_i.byte_count;
  assign sub_left_dec = state_i.sub_bytes_left - 2'd1;
  assign bytes_dec    = state_i.bytes_left - 8'd1;
  assign pos_inc      = state_i.buffer_position + 8'd1;

  always_comb begin
    state_t s;
    out_t   r;
    s = state_i;
    r = '0;
    if (item_i.command == CMD_IN_START) begin
      if (state_i.phase == PH_IDLE && item_i.kind <= KIND_RAW_READ) begin
        if ((item_i.kind == KIND_RAW_WRITE || item_i.kind == KIND_RAW_READ) &&
            item_i.byte_count < 8'd2) begin
          r.rejected = 1'b1;
        end else begin
          case (item_i.kind)
            KIND_BYTE_WRITE: begin
              s.held_slave_address = sla;
              s.read_after_address = 1'b0;
              r.address_valid      = 1'b1;
              r.slave_address      = sla;
              r.put_valid          = 1'b1;
              r.put_byte           = item_i.write_byte;
              r.master_command     = CMD_SINGLE_SEND;
              s.bytes_left         = 8'd0;
              s.buffer_position    = 8'd1;
              s.phase              = PH_WRITE_ONE;
            end
            KIND_RAW_WRITE: begin
              s.held_slave_address = sla;
              s.read_after_address = 1'b0;
              s.sub_bytes_left     = 2'd0;
              r.address_valid      = 1'b1;
              r.slave_address      = sla;
              r.put_valid          = 1'b1;
              r.put_byte           = item_i.write_byte;
              r.master_command     = CMD_SEND_START;
              s.bytes_left         = item_i.byte_count - 8'd1;
              s.buffer_position    = 8'd1;
              s.phase = (item_i.byte_count == 8'd2) ? PH_WRITE_FINAL : PH_WRITE_NEXT;
            end
            KIND_BYTE_READ: begin
              s.held_slave_address = sla;
              s.read_after_address = 1'b0;
              r.address_valid      = 1'b1;
              r.slave_address      = sla;
              r.read_direction     = 1'b1;
              r.master_command     = CMD_SINGLE_RECV;
              s.bytes_left         = 8'd1;
              s.buffer_position    = 8'd0;
              s.phase              = PH_READ_WAIT;
            end
            KIND_RAW_READ: begin
              s.held_slave_address = sla;
              s.read_after_address = 1'b0;
              r.address_valid      = 1'b1;
              r.slave_address      = sla;
              r.read_direction     = 1'b1;
              r.master_command     = CMD_RECV_START;
              s.bytes_left         = item_i.byte_count;
              s.buffer_position    = 8'd0;
              s.phase = (item_i.byte_count == 8'd2) ? PH_READ_FINAL : PH_READ_NEXT;
            end
            default: begin
              // Subaddress write or read.
              s.held_slave_address = sla_sub;
              s.held_sub_address   = item_i.sub_address;
              s.bytes_left         = count_sub;
              s.buffer_position    = 8'd0;
              s.read_after_address = (item_i.kind == KIND_SUB_READ);
              s.sub_bytes_left     = nsub - 2'd1;
              r.address_valid      = 1'b1;
              r.slave_address      = sla_sub;
              r.put_valid          = 1'b1;
              r.put_byte           = sub_byte(item_i.sub_address, nsub - 2'd1);
              r.master_command     = CMD_SEND_START;
              if (item_i.kind == KIND_SUB_WRITE) begin
                s.phase = (nsub == 2'd1 && count_sub == 8'd1) ? PH_WRITE_FINAL
                                                              : PH_WRITE_NEXT;
              end else if (nsub == 2'd1) begin
                s.phase = (count_sub == 8'd1) ? PH_READ_ONE : PH_READ_FIRST;
              end else begin
                s.phase = PH_WRITE_NEXT;
              end
            end
          endcase
        end
      end
    end else begin
      unique case (state_i.phase)
        PH_WRITE_ONE: s.phase = PH_IDLE;
        PH_WRITE_NEXT: begin
          r.put_valid = 1'b1;
          if (state_i.sub_bytes_left != 2'd0) begin
            s.sub_bytes_left = sub_left_dec;
            r.put_byte       = sub_byte(state_i.held_sub_address, sub_left_dec);
            if (sub_left_dec == 2'd0) begin
              if (state_i.read_after_address) begin
                s.phase = (state_i.bytes_left == 8'd1) ? PH_READ_ONE : PH_READ_FIRST;
              end else if (state_i.bytes_left == 8'd1) begin
                s.phase = PH_WRITE_FINAL;
              end
            end
          end else begin
            r.put_byte        = item_i.write_byte;
            s.buffer_position = pos_inc;
            s.bytes_left      = bytes_dec;
            if (bytes_dec == 8'd1) s.phase = PH_WRITE_FINAL;
          end
          r.master_command = CMD_SEND_CONT;
        end
        PH_WRITE_FINAL: begin
          r.put_valid       = 1'b1;
          r.put_byte        = item_i.write_byte;
          s.buffer_position = pos_inc;
          s.bytes_left      = bytes_dec;
          r.master_command  = CMD_SEND_FINISH;
          s.phase           = PH_IDLE;
        end
        PH_READ_ONE: begin
          r.address_valid  = 1'b1;
          r.slave_address  = state_i.held_slave_address;
          r.read_direction = 1'b1;
          r.master_command = CMD_SINGLE_RECV;
          s.phase          = PH_READ_WAIT;
        end
        PH_READ_FIRST: begin
          r.address_valid  = 1'b1;
          r.slave_address  = state_i.held_slave_address;
          r.read_direction = 1'b1;
          r.master_command = CMD_RECV_START;
          s.phase = (state_i.bytes_left == 8'd2) ? PH_READ_FINAL : PH_READ_NEXT;
        end
        PH_READ_NEXT: begin
          r.store_valid     = 1'b1;
          r.store_byte      = item_i.read_byte;
          s.buffer_position = pos_inc;
          s.bytes_left      = bytes_dec;
          r.master_command  = CMD_RECV_CONT;
          if (bytes_dec == 8'd2) s.phase = PH_READ_FINAL;
        end
        PH_READ_FINAL: begin
          r.store_valid     = 1'b1;
          r.store_byte      = item_i.read_byte;
          s.buffer_position = pos_inc;
          s.bytes_left      = bytes_dec;
          r.master_command  = CMD_RECV_FINISH;
          s.phase           = PH_READ_WAIT;
        end
        PH_READ_WAIT: begin
          r.store_valid     = 1'b1;
          r.store_byte      = item_i.read_byte;
          s.buffer_position = pos_inc;
          s.bytes_left      = bytes_dec;
          s.phase           = PH_IDLE;
        end
        default: s.phase = PH_IDLE;
      endcase
    end
    r.next_index = s.buffer_position;
    r.busy_res   = (s.phase != PH_IDLE);
    state_o  = s;
    result_o = r;
  end

endmodule
`default_nettype wire

>>> hdl/i2c_master_transaction_sequencer_top.sv
// Top level of the I2C master transaction sequencer: input stage, state and result register.
// A word accepted into the input register passes through the step logic into the result
// register once that register is empty or drained. Throughput: one word per cycle while
// out_ready_i keeps the result register drained; the input register feeds the step logic,
// whose result lands in the output register while the sequencer state updates alongside.
// Reset clears the phase and all held state to zero/idle and empties both stages.
`default_nettype none
module i2c_master_transaction_sequencer_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  i2cms_pkg::in_t     in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output i2cms_pkg::out_t    out_data_o
);
  import i2cms_pkg::*;

  // Input stage: holds one accepted word until the step logic consumes it.
  logic   in_valid_q;
  in_t    in_data_q;

  // Sequencer state, advanced once for each word that leaves the input stage.
  state_t state_q;
  state_t state_d;

  // Result register facing the consumer.
  logic   out_valid_q;
  out_t   out_data_q;
  out_t   result_d;

  logic   advance;

  // A word moves from the input stage to the result register whenever the result
  // register is empty or is being drained in the same cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  i2cms_step u_step (
    .state_i  (state_q),
    .item_i   (in_data_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A refused start leaves the sequencer idle and issues no command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.rejected |->
      out_data_q.master_command == CMD_NONE && !out_data_q.busy_res)
    else $error("rejected start issued a command or left the sequencer busy");

  // A result never carries both a byte to send and a byte to store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.put_valid && out_data_q.store_valid))
    else $error("result both sends and stores a byte");

  // Every word that leaves the input stage shows up as a result word next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("consumed word produced no result");

  // The busy flag of the latest result tracks the held phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_data_q.busy_res == (state_q.phase != PH_IDLE))
    else $error("busy flag disagrees with the sequencer phase");

endmodule
`default_nettype wire
